>>> design/aesd_pkg.sv
// aesd_pkg: shared types, s-box tables and gf(2^8) helpers for the aes-128 decrypt block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package aesd_pkg;

    localparam int BLOCK_W = 128;
    localparam int ROUNDS  = 10;
    // cycles from a key write until the last round key register holds its new value
    localparam int KEY_SETTLE_CYCLES = ROUNDS + 1;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [7:0]         byte_t;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } reg_idx_t;

    function automatic byte_t xtime(input byte_t a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic byte_t gmul(input byte_t a, input logic [3:0] b);
        byte_t p;
        byte_t x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
                p = p ^ x;
            x = xtime(x);
        end
        gmul = p;
    endfunction

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // byte i of the block, i = c*4 + r, row 0 in the msb of each column
    function automatic byte_t get_byte(input block_t s, input int i);
        get_byte = s[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic block_t inv_shift_sub(input block_t s);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[BLOCK_W-1-8*(c*4+r) -: 8] = INV_SBOX[get_byte(s, ((c - r + 4) % 4) * 4 + r)];
            end
        end
        inv_shift_sub = t;
    endfunction

    function automatic block_t inv_mix(input block_t s);
        block_t t;
        byte_t a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, c*4);
            a1 = get_byte(s, c*4+1);
            a2 = get_byte(s, c*4+2);
            a3 = get_byte(s, c*4+3);
            t[BLOCK_W-1-8*(c*4) -: 8]   = gmul(a0,4'd14)^gmul(a1,4'd11)^gmul(a2,4'd13)^gmul(a3,4'd9);
            t[BLOCK_W-1-8*(c*4+1) -: 8] = gmul(a0,4'd9)^gmul(a1,4'd14)^gmul(a2,4'd11)^gmul(a3,4'd13);
            t[BLOCK_W-1-8*(c*4+2) -: 8] = gmul(a0,4'd13)^gmul(a1,4'd9)^gmul(a2,4'd14)^gmul(a3,4'd11);
            t[BLOCK_W-1-8*(c*4+3) -: 8] = gmul(a0,4'd11)^gmul(a1,4'd13)^gmul(a2,4'd9)^gmul(a3,4'd14);
        end
        inv_mix = t;
    endfunction

    function automatic logic [31:0] sub_rot_word(input logic [31:0] w);
        logic [31:0] r;
        r = {w[23:0], w[31:24]};
        sub_rot_word = {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
    endfunction

    // one key expansion round: next round key from the current one
    function automatic block_t next_key(input block_t k, input byte_t rcon);
        logic [31:0] w0, w1, w2, w3;
        w0 = k[127:96] ^ sub_rot_word(k[31:0]) ^ {rcon, 24'h0};
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

>>> design/aesd_key_exp.sv
// aesd_key_exp: key registers with apb write, registered round key expansion
// depends on aesd_pkg
`timescale 1ns / 1ps
`default_nettype none
module aesd_key_exp
    import aesd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic         wr_idx,
    input  wire logic [63:0]  wr_data,
    output logic [63:0]       key_high,
    output logic [63:0]       key_low,
    output block_t            round_keys [ROUNDS+1],
    output logic              keys_ready
);

    logic [63:0] key_high_reg, key_low_reg;
    block_t      rk_reg [ROUNDS+1];
    block_t      rk_next [ROUNDS+1];
    logic [3:0]  settle_reg;
    logic [3:0]  settle_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (wr_en)
        begin
            if (wr_idx == REG_KEY_HIGH)
                key_high_reg <= wr_data;
            else
                key_low_reg <= wr_data;
        end
    end

    // each round key registered from the previous one
    always_comb
    begin
        byte_t rc;
        rc = 8'h01;
        rk_next[0] = {key_high_reg, key_low_reg};
        for (int i = 1; i <= ROUNDS; i++)
        begin
            rk_next[i] = next_key(rk_reg[i-1], rc);
            rc = xtime(rc);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= ROUNDS; i++)
            rk_reg[i] <= rk_next[i];
    end

    // countdown until the whole chain holds the current key
    always_comb
    begin
        if (wr_en)
            settle_next = 4'(KEY_SETTLE_CYCLES);
        else if (settle_reg != 4'd0)
            settle_next = settle_reg - 4'd1;
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= 4'(KEY_SETTLE_CYCLES);
        else
            settle_reg <= settle_next;
    end

    assign key_high   = key_high_reg;
    assign key_low    = key_low_reg;
    assign round_keys = rk_reg;
    assign keys_ready = (settle_reg == 4'd0);

endmodule
`default_nettype wire

>>> design/aesd_round.sv
// aesd_round: one pipeline stage of the inverse cipher
// depends on aesd_pkg
`timescale 1ns / 1ps
`default_nettype none
module aesd_round
    import aesd_pkg::*;
#(
    parameter bit FIRST = 1'b0
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   in_valid,
    input  block_t      in_data,
    input  block_t      round_key,
    output logic        out_valid,
    output block_t      out_data
);

    logic   valid_reg;
    block_t data_reg;
    block_t mixed;

    // first stage skips inverse mixcolumns
    always_comb
    begin
        if (FIRST)
            mixed = in_data ^ round_key;
        else
            mixed = inv_mix(in_data ^ round_key);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= inv_shift_sub(mixed);
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> design/aes128_block_decrypt.sv
// aes128_block_decrypt: pipelined aes-128 ecb decryption with apb key port
// depends on aesd_pkg, aesd_key_exp, aesd_round
`timescale 1ns / 1ps
`default_nettype none
// Decrypts one 128-bit block per cycle. Ten round stages and an output
// stage hold a block each; an accepted request passes through the round
// stages and then the output register before its result shows on m_axis.
// Throughput is one block per clock, limited by the downstream tready (the
// whole pipe advances when the output register is empty or being drained)
// and by key loading. Keys are written through apb at address 0 (key_high)
// and 8 (key_low); the round keys are re-expanded by a registered chain,
// and s_axis_tready stays low after reset or any key write while the chain
// settles. Write keys only while no request is in flight.
// tdata on both sides: bits 63:0 high half (columns 0,1), 127:64 low half.
module aes128_block_decrypt
    import aesd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // cipher_high [63:0], cipher_low [127:64]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata    // plain_high [63:0], plain_low [127:64]
);

    logic   wr_en;
    logic   adv;
    logic   keys_ready;
    logic [63:0] key_high, key_low;
    block_t round_keys [ROUNDS+1];
    logic   v [ROUNDS+1];
    block_t d [ROUNDS+1];
    logic   out_valid_reg;
    block_t out_data_reg;

    assign pready = 1'b1;
    // only the two register slots decode for writes; other write addresses are ignored
    assign wr_en  = psel && penable && pwrite && (paddr[2:0] == 3'd0) && (paddr[3:3] == 1'b0
                    || paddr[3:3] == 1'b1);
    assign prdata = (paddr[3] == REG_KEY_LOW) ? key_low : key_high;

    aesd_key_exp u_key (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en && paddr[2:0] == 3'd0),
        .wr_idx     (paddr[3]),
        .wr_data    (pwdata),
        .key_high   (key_high),
        .key_low    (key_low),
        .round_keys (round_keys),
        .keys_ready (keys_ready)
    );

    // pipe advances when the output slot is free or taken this cycle
    assign adv           = !out_valid_reg || m_axis_tready;
    // requests held off until the round keys match the key registers
    assign s_axis_tready = adv && keys_ready;

    // block words: high half holds columns 0,1
    assign v[0] = s_axis_tvalid && keys_ready;
    assign d[0] = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    genvar g;
    generate
        for (g = 0; g < ROUNDS; g++)
        begin : g_round
            aesd_round #(.FIRST(g == 0)) u_round (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (v[g]),
                .in_data   (d[g]),
                .round_key (round_keys[ROUNDS-g]),
                .out_valid (v[g+1]),
                .out_data  (d[g+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v[ROUNDS];
    end

    // final add of the cipher key
    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= d[ROUNDS] ^ round_keys[0];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg[63:0], out_data_reg[127:64]};

endmodule
`default_nettype wire

>>> design/aesd_checker.sv
// aesd_checker: port-level assertions for aes128_block_decrypt
// depends on aes128_block_decrypt ports
`timescale 1ns / 1ps
`default_nettype none
module aesd_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata,
    input wire logic         pready
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_known_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_axis_tready, m_axis_tvalid}))
        else $error("handshake output unknown");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind aes128_block_decrypt aesd_checker u_aesd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
`default_nettype wire

>>> tb/sv/aes128_block_decrypt_tb.sv
// aes128_block_decrypt_tb: self-checking bench for the aes-128 ecb decrypt block
// depends on aesd_pkg and aes128_block_decrypt; builds its own aes tables and key schedule
`timescale 1ns / 1ps
module aes128_block_decrypt_tb;
    import aesd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PIPE_DEPTH  = 11;   // round stages plus output stage
    localparam int KEY_SETTLE  = 15;   // wait for the registered key chain to settle

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } half_pair_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic pready;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata;   // cipher_high [63:0], cipher_low [127:64]
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [127:0] m_axis_tdata;   // plain_high [63:0], plain_low [127:64]

    // stimulus and expectation stores
    half_pair_t cipher_queue[$];
    half_pair_t plain_expected[$];

    // local copy of the key and its schedule
    logic [63:0]  key_hi_shadow;
    logic [63:0]  key_lo_shadow;
    logic [127:0] round_keys [0:10];
    byte_t        fwd_box [256];
    byte_t        inv_box [256];

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_sender;
    int error_count;
    int cycle_count;

    aes128_block_decrypt dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // gf(2^8) multiply, reduction polynomial 0x11b
    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        byte_t p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // s-box from the multiplicative inverse plus the affine map
    function automatic void build_boxes();
        byte_t v;
        byte_t s;
        for (int x = 0; x < 256; x++)
        begin
            v = 8'h00;
            for (int y = 1; y < 256 && x != 0; y++)
            begin
                if (gf_mul(byte_t'(x), byte_t'(y)) == 8'h01)
                begin
                    v = byte_t'(y);
                    break;
                end
            end
            s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]} ^ 8'h63;
            fwd_box[x] = s;
            inv_box[s] = byte_t'(x);
        end
    endfunction

    function automatic void expand_schedule();
        logic [31:0] w [0:43];
        logic [31:0] t;
        byte_t rc;
        rc = 8'h01;
        {w[0], w[1]} = key_hi_shadow;
        {w[2], w[3]} = key_lo_shadow;
        for (int i = 4; i < 44; i++)
        begin
            t = w[i-1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
                t = t ^ {rc, 24'h0};
                rc = gf_mul(rc, 8'h02);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int k = 0; k <= 10; k++)
            round_keys[k] = {w[4*k], w[4*k+1], w[4*k+2], w[4*k+3]};
    endfunction

    // byte i of the state sits at bits 127-8i, i = column*4 + row
    function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(c*4+r) -: 8] = inv_box[s[127-8*(((c-r+4)%4)*4+r) -: 8]];
        return t;
    endfunction

    function automatic logic [127:0] unmix_columns(input logic [127:0] s);
        logic [127:0] t;
        byte_t a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            {a0, a1, a2, a3} = s[127-32*c -: 32];
            t[127-32*c -: 32] = {
                gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9),
                gf_mul(a0, 8'd9)  ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13),
                gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9)  ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11),
                gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)  ^ gf_mul(a3, 8'd14)};
        end
        return t;
    endfunction

    function automatic half_pair_t decrypt_block(input half_pair_t cipher);
        logic [127:0] st;
        st = unshift_unsub({cipher.hi, cipher.lo} ^ round_keys[10]);
        for (int rnd = 9; rnd >= 1; rnd--)
            st = unshift_unsub(unmix_columns(st ^ round_keys[rnd]));
        st = st ^ round_keys[0];
        return '{hi: st[127:64], lo: st[63:0]};
    endfunction

    // driver: predicts on each accepted request, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                plain_expected.push_back(
                    decrypt_block('{hi: s_axis_tdata[63:0], lo: s_axis_tdata[127:64]}));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (cipher_queue.size() > 0 && !hold_sender
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    half_pair_t nxt;
                    nxt = cipher_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {nxt.lo, nxt.hi};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: random back-pressure and in-order compare of results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (plain_expected.size() == 0)
                begin
                    $error("unexpected result %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    half_pair_t want;
                    want = plain_expected.pop_front();
                    if (m_axis_tdata[63:0] !== want.hi)
                    begin
                        $error("plain_high: expected %h actual %h", want.hi, m_axis_tdata[63:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[127:64] !== want.lo)
                    begin
                        $error("plain_low: expected %h actual %h", want.lo, m_axis_tdata[127:64]);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // wait until every queued request has gone in and every result has come out
    task automatic wait_drained();
        while (cycle_count >= 0)
        begin
            @(posedge clk);
            if (cipher_queue.size() == 0 && !s_axis_tvalid && plain_expected.size() == 0)
                break;
        end
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle
    task automatic write_key(input reg_idx_t idx, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(8 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_KEY_HIGH)
            key_hi_shadow = value;
        else
            key_lo_shadow = value;
        expand_schedule();
        repeat (KEY_SETTLE) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_cipher(input logic [63:0] hi, input logic [63:0] lo);
        cipher_queue.push_back('{hi: hi, lo: lo});
    endtask

    initial
    begin
        logic [63:0] key_sets [0:5][0:1];
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_sender    = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        key_hi_shadow  = '0;
        key_lo_shadow  = '0;
        build_boxes();
        expand_schedule();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (KEY_SETTLE) @(posedge clk);

        // directed: reset key (all zero), then field extremes, alternating bits and a single-bit pattern
        queue_cipher('0, '0);
        queue_cipher('1, '1);
        queue_cipher(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        queue_cipher(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        queue_cipher(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
        queue_cipher('1, '0);
        queue_cipher('0, '1);
        wait_drained();

        // directed: known-answer key, plus zero, all-ones and walking-bit blocks
        write_key(REG_KEY_HIGH, 64'h0001_0203_0405_0607);
        write_key(REG_KEY_LOW,  64'h0809_0a0b_0c0d_0e0f);
        queue_cipher(64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
        queue_cipher('0, '0);
        queue_cipher('1, '1);
        for (int b = 0; b < 64; b += 9)
            queue_cipher(64'h1 << b, 64'h1 << (63 - b));
        wait_drained();

        // random phases across key settings and idle modes
        key_sets[0] = '{'1, '1};
        key_sets[1] = '{'0, '0};
        key_sets[2] = '{rand64(), rand64()};
        key_sets[3] = '{'1, '0};
        key_sets[4] = '{rand64(), rand64()};
        key_sets[5] = '{rand64(), rand64()};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_key(REG_KEY_HIGH, key_sets[ph][0]);
            write_key(REG_KEY_LOW,  key_sets[ph][1]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            for (int n = 0; n < 255; n++)
                queue_cipher(rand64(), rand64());
            if (ph == 2)
            begin
                // sender holds off mid-phase until the pipe is empty
                wait (cipher_queue.size() < 120);
                hold_sender = 1'b1;
                while (plain_expected.size() != 0 || s_axis_tvalid)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            wait_drained();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (error_count == 0 && plain_expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
design/aesd_pkg.sv
design/aesd_key_exp.sv
design/aesd_round.sv
design/aes128_block_decrypt.sv
design/aesd_checker.sv
tb/sv/aes128_block_decrypt_tb.sv
